// ===== rtl/cbt_pkg.sv =====
package cbt_pkg;

    // Width of the level-of-detail register and its value after reset.
    localparam int          LOD_W     = 6;
    localparam logic [5:0]  LOD_RESET = 6'd16;

    // Parameter u in Q1.16; it reaches exactly 1.0, so it needs 17 bits.
    localparam int U_FRAC  = 16;
    localparam int U_W     = U_FRAC + 1;
    localparam int ONE_Q16 = 65536;

    // Working width for the weight sums and the stored width of a weight.
    localparam int CALC_W = 22;
    localparam int WGT_W  = 20;

    // Half of the 6 * 2^16 divisor, added before truncation to round.
    localparam int ROUND_HALF = 196608;

    // Depth of the segment queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Reciprocal of the interval count: 2^16 = quot * n + rem.
    typedef struct packed {
        logic             ready;
        logic [U_W-1:0]   quot;
        logic [LOD_W-1:0] rem;
    } t_recip;

    // A level of detail of zero is treated as one interval.
    function automatic logic [LOD_W-1:0] lod_eff(input logic [LOD_W-1:0] lod);
        return (lod == '0) ? LOD_W'(1) : lod;
    endfunction

endpackage

// ===== rtl/cubic_bspline_tessellator.sv =====
// Channel   Direction  Handshake                 Payload
// config    in         i_cfg_we                  i_cfg_wdata (lod)
// points    in         i_in_valid / o_in_stall   i_point_x, i_point_y, i_first_point
// curve     out        o_out_valid / i_out_stall o_curve_x, o_curve_y, o_last_in_run
//
// Every control point that completes a four-point window yields lod+1 curve points
// from the evaluation pipeline (two when lod is zero), one curve point per cycle
// while the curve channel does not stall, with no gap between segments.
// From the window to the first curve point the data passes the parameter generator,
// the evaluation registers, the divide-by-three chain and the output register.
// After reset and after each write of lod the reciprocal unit must finish its division
// before evaluation starts; points are still taken into the queue meanwhile.
// Reset is synchronous and active low. A stall while a curve point is shown freezes the
// whole evaluation pipeline; the two-entry queue keeps taking points until it is full.
module cubic_bspline_tessellator #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [5:0]             i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    input  logic                   i_first_point,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COORD_WIDTH-1:0] o_curve_x,
    output logic [COORD_WIDTH-1:0] o_curve_y,
    output logic                   o_last_in_run
);
    import cbt_pkg::*;

    // The level of detail: number of intervals per segment. A value of zero
    // behaves as one interval.
    logic [LOD_W-1:0] r_lod;

    // Window handed from the front to the queue, and from the queue to the back.
    // Lane 0 carries x and lane 1 carries y; entry 0 is the oldest point.
    logic [1:0][3:0][COORD_WIDTH-1:0] w_push_win;
    logic [1:0][3:0][COORD_WIDTH-1:0] w_job_win;
    logic                             w_push;
    logic                             w_q_full;
    logic                             w_q_nonempty;
    logic                             w_pop;
    t_recip                           w_recip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lod <= LOD_RESET;
        end else if (i_cfg_we) begin
            r_lod <= i_cfg_wdata;
        end
    end

    // The front takes one point per transaction, keeps the sliding window and
    // the count of points held in the current curve, and queues every window
    // that is complete. It stalls only while the queue is full.
    cbt_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_first_point (i_first_point),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_window      (w_push_win)
    );

    // Short queue of complete windows, so that the front and the evaluation
    // pipeline can stall independently.
    cbt_queue #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_push_win),
        .i_pop      (w_pop),
        .o_full     (w_q_full),
        .o_nonempty (w_q_nonempty),
        .o_data     (w_job_win)
    );

    // The parameter step 1/lod is kept as a Q1.16 quotient and remainder. It is
    // recomputed bit-serially after reset and whenever lod is written.
    cbt_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_lod   (r_lod),
        .o_recip (w_recip)
    );

    // The back steps u through the segment by exact quotient and remainder
    // accumulation, forms the four basis weights, multiplies and sums them with
    // the window, then rounds, divides by three and saturates.
    cbt_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lod       (r_lod),
        .i_recip     (w_recip),
        .i_job_valid (w_q_nonempty),
        .i_job       (w_job_win),
        .o_job_pop   (w_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_x         (o_curve_x),
        .o_y         (o_curve_y),
        .o_last      (o_last_in_run)
    );

endmodule

// ===== rtl/cbt_front.sv =====
module cbt_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [COORD_WIDTH-1:0]             i_point_x,
    input  logic [COORD_WIDTH-1:0]             i_point_y,
    input  logic                               i_first_point,
    input  logic                               i_q_full,
    output logic                               o_push,
    output logic [1:0][3:0][COORD_WIDTH-1:0]   o_window
);
    import cbt_pkg::*;

    localparam logic [2:0] HOLD_FULL = 3'd4;

    logic [1:0][3:0][COORD_WIDTH-1:0] r_win;
    logic [1:0][3:0][COORD_WIDTH-1:0] n_win;
    logic [2:0]                       r_held;
    logic [2:0]                       n_held;
    logic [2:0]                       v_base;
    logic                             v_accept;

    assign v_accept = i_valid && !i_q_full;
    assign o_stall  = i_q_full;

    always_comb begin
        v_base = i_first_point ? 3'd0 : r_held;
        n_held = (v_base < HOLD_FULL) ? v_base + 3'd1 : HOLD_FULL;
        n_win[0] = {i_point_x, r_win[0][3:1]};
        n_win[1] = {i_point_y, r_win[1][3:1]};
    end

    // A full window is handed to the queue at the edge the point is taken.
    assign o_push   = v_accept && (n_held == HOLD_FULL);
    assign o_window = n_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (v_accept) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== rtl/cbt_queue.sv =====
module cbt_queue #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [1:0][3:0][COORD_WIDTH-1:0]   i_data,
    input  logic                               i_pop,
    output logic                               o_full,
    output logic                               o_nonempty,
    output logic [1:0][3:0][COORD_WIDTH-1:0]   o_data
);
    import cbt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [1:0][3:0][COORD_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]                 r_wp;
    logic [PTR_W-1:0]                 r_rp;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             v_push;
    logic                             v_pop;

    assign o_full     = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];
    assign v_push     = i_push && !o_full;
    assign v_pop      = i_pop && o_nonempty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (v_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (v_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (v_push && !v_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (v_pop && !v_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/cbt_recip.sv =====
module cbt_recip (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cbt_pkg::LOD_W-1:0] i_lod,
    output cbt_pkg::t_recip           o_recip
);
    import cbt_pkg::*;

    localparam int CNT_W = $clog2(U_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [LOD_W-1:0]     r_rem;
    logic [U_W-1:0]       r_quot;
    logic [LOD_W-1:0]     v_n;
    logic [LOD_W:0]       v_try;
    logic                 v_ge;

    // Restoring division of 2^16 by n, one quotient bit per cycle, MSB first.
    always_comb begin
        v_n   = lod_eff(i_lod);
        v_try = {r_rem, (r_cnt == CNT_W'(U_W - 1))};
        v_ge  = (v_try >= {1'b0, v_n});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(U_W - 1);
            r_rem  <= '0;
            r_quot <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(U_W - 1);
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= v_ge ? LOD_W'(v_try - {1'b0, v_n}) : v_try[LOD_W-1:0];
            r_quot <= {r_quot[U_W-2:0], v_ge};
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_recip.ready = !r_busy;
    assign o_recip.quot  = r_quot;
    assign o_recip.rem   = r_rem;

endmodule

// ===== rtl/cbt_back.sv =====
module cbt_back #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [cbt_pkg::LOD_W-1:0]          i_lod,
    input  cbt_pkg::t_recip                    i_recip,
    input  logic                               i_job_valid,
    input  logic [1:0][3:0][COORD_WIDTH-1:0]   i_job,
    output logic                               o_job_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [COORD_WIDTH-1:0]             o_x,
    output logic [COORD_WIDTH-1:0]             o_y,
    output logic                               o_last
);
    import cbt_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = WGT_W + CW;
    localparam int AW  = PW + 2;
    localparam int TW  = AW - U_FRAC;
    localparam int DS  = (TW + 7) / 8;
    localparam int TPW = DS * 8;

    localparam logic signed [CALC_W-1:0] C_ONE  = CALC_W'(ONE_Q16);
    localparam logic signed [CALC_W-1:0] C_FOUR = CALC_W'(4 * ONE_Q16);
    localparam logic [TPW-1:0] LIM_POS = {{(TPW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [TPW-1:0] LIM_NEG = LIM_POS + TPW'(1);

    typedef logic [1:0][3:0][CW-1:0] t_win;

    logic               v_en;
    logic [LOD_W-1:0]   v_n;
    logic               v_start;

    // Parameter generator.
    logic               r_gbusy;
    logic [LOD_W-1:0]   r_k;
    logic [U_W-1:0]     r_u;
    logic [LOD_W-1:0]   r_ures;
    t_win               r_gp;
    logic [LOD_W:0]     v_rsum;
    logic               v_wrap;

    // Evaluation stages.
    logic               r1_v, r2_v, r3_v, r4_v, r5_v;
    logic               r1_l, r2_l, r3_l, r4_l, r5_l;
    logic [U_W-1:0]     r1_u, r1_u2, r2_u, r2_u2, r2_u3;
    t_win               r1_p, r2_p, r3_p;
    logic [2*U_W-1:0]   v_uu, v_uuu;
    logic signed [WGT_W-1:0] r3_w [4];
    logic signed [CALC_W-1:0] v_su, v_su2, v_su3;
    logic signed [CALC_W-1:0] v_w [4];
    logic signed [PW-1:0] r4_prod [2][4];
    logic signed [AW-1:0] r5_acc [2];
    logic [AW-1:0]      v_mag [2];
    logic [AW:0]        v_rnd [2];

    // Division by three, eight quotient bits per stage.
    logic               r_dv   [DS+1];
    logic               r_dl   [DS+1];
    logic               r_dneg [DS+1][2];
    logic [TPW-1:0]     r_dw   [DS+1][2];
    logic [1:0]         r_dr   [DS+1][2];
    logic [TPW-1:0]     n_dw   [1:DS][2];
    logic [1:0]         n_dr   [1:DS][2];

    // Output register.
    logic               r_o_valid;
    logic               r_o_last;
    logic [CW-1:0]      r_o_c [2];
    logic [CW-1:0]      v_sat [2];

    assign v_en      = !r_o_valid || !i_stall;
    assign v_n       = lod_eff(i_lod);
    assign v_start   = v_en && i_recip.ready && i_job_valid && (!r_gbusy || (r_k == v_n));
    assign o_job_pop = v_start;

    always_comb begin
        v_rsum = {1'b0, r_ures} + {1'b0, i_recip.rem};
        v_wrap = (v_rsum >= {1'b0, v_n});
    end

    always_comb begin
        v_uu  = r_u * r_u;
        v_uuu = r1_u2 * r1_u;
    end

    always_comb begin
        v_su  = $signed({{(CALC_W-U_W){1'b0}}, r2_u});
        v_su2 = $signed({{(CALC_W-U_W){1'b0}}, r2_u2});
        v_su3 = $signed({{(CALC_W-U_W){1'b0}}, r2_u3});
        v_w[0] = C_ONE - (v_su + (v_su <<< 1)) + (v_su2 + (v_su2 <<< 1)) - v_su3;
        v_w[1] = C_FOUR - ((v_su2 <<< 2) + (v_su2 <<< 1)) + (v_su3 + (v_su3 <<< 1));
        v_w[2] = C_ONE + (v_su + (v_su <<< 1)) + (v_su2 + (v_su2 <<< 1))
                 - (v_su3 + (v_su3 <<< 1));
        v_w[3] = v_su3;
    end

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            v_mag[c] = r5_acc[c][AW-1] ? AW'(-r5_acc[c]) : AW'(r5_acc[c]);
            v_rnd[c] = {1'b0, v_mag[c]} + (AW+1)'(ROUND_HALF);
        end
    end

    always_comb begin : div_steps
        logic [TPW-1:0] v_work;
        logic [1:0]     v_rem;
        logic [2:0]     v_try;
        for (int j = 1; j <= DS; j++) begin
            for (int c = 0; c < 2; c++) begin
                v_work = r_dw[j-1][c];
                v_rem  = r_dr[j-1][c];
                for (int b = 0; b < 8; b++) begin
                    v_try  = {v_rem, v_work[TPW-1]};
                    v_work = {v_work[TPW-2:0], 1'b0};
                    if (v_try >= 3'd3) begin
                        v_try     = v_try - 3'd3;
                        v_work[0] = 1'b1;
                    end
                    v_rem = v_try[1:0];
                end
                n_dw[j][c] = v_work;
                n_dr[j][c] = v_rem;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            if (r_dneg[DS][c]) begin
                v_sat[c] = (r_dw[DS][c] > LIM_NEG) ? {1'b1, {(CW-1){1'b0}}}
                                                    : CW'(-r_dw[DS][c][CW-1:0]);
            end else begin
                v_sat[c] = (r_dw[DS][c] > LIM_POS) ? {1'b0, {(CW-1){1'b1}}}
                                                    : r_dw[DS][c][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gbusy   <= 1'b0;
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r5_v      <= 1'b0;
            r_o_valid <= 1'b0;
            for (int j = 0; j <= DS; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else if (v_en) begin
            if (v_start) begin
                r_gbusy <= 1'b1;
            end else if (r_k == v_n) begin
                r_gbusy <= 1'b0;
            end
            r1_v    <= r_gbusy;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r_dv[0] <= r5_v;
            for (int j = 1; j <= DS; j++) begin
                r_dv[j] <= r_dv[j-1];
            end
            r_o_valid <= r_dv[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_en) begin
            if (v_start) begin
                r_k    <= '0;
                r_u    <= '0;
                r_ures <= '0;
                r_gp   <= i_job;
            end else if (r_gbusy) begin
                r_k    <= r_k + LOD_W'(1);
                r_u    <= r_u + i_recip.quot + U_W'(v_wrap);
                r_ures <= v_wrap ? LOD_W'(v_rsum - {1'b0, v_n}) : v_rsum[LOD_W-1:0];
            end

            r1_l  <= (r_k == v_n);
            r1_u  <= r_u;
            r1_u2 <= v_uu[U_FRAC+U_W-1:U_FRAC];
            r1_p  <= r_gp;

            r2_l  <= r1_l;
            r2_u  <= r1_u;
            r2_u2 <= r1_u2;
            r2_u3 <= v_uuu[U_FRAC+U_W-1:U_FRAC];
            r2_p  <= r1_p;

            r3_l <= r2_l;
            r3_p <= r2_p;
            for (int i = 0; i < 4; i++) begin
                r3_w[i] <= v_w[i][WGT_W-1:0];
            end

            r4_l <= r3_l;
            for (int c = 0; c < 2; c++) begin
                for (int i = 0; i < 4; i++) begin
                    r4_prod[c][i] <= r3_w[i] * $signed(r3_p[c][i]);
                end
            end

            r5_l <= r4_l;
            for (int c = 0; c < 2; c++) begin
                r5_acc[c] <= AW'(r4_prod[c][0]) + AW'(r4_prod[c][1])
                           + AW'(r4_prod[c][2]) + AW'(r4_prod[c][3]);
            end

            // The rounded magnitude is divided by 2^17 here and by three below,
            // which together divide by 6 * 2^16.
            r_dl[0] <= r5_l;
            for (int c = 0; c < 2; c++) begin
                r_dneg[0][c] <= r5_acc[c][AW-1];
                r_dw[0][c]   <= TPW'(v_rnd[c][AW:U_FRAC+1]);
                r_dr[0][c]   <= '0;
            end
            for (int j = 1; j <= DS; j++) begin
                r_dl[j] <= r_dl[j-1];
                for (int c = 0; c < 2; c++) begin
                    r_dneg[j][c] <= r_dneg[j-1][c];
                    r_dw[j][c]   <= n_dw[j][c];
                    r_dr[j][c]   <= n_dr[j][c];
                end
            end

            r_o_last <= r_dl[DS];
            for (int c = 0; c < 2; c++) begin
                r_o_c[c] <= v_sat[c];
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_x     = r_o_c[0];
    assign o_y     = r_o_c[1];
    assign o_last  = r_o_last;

endmodule
